@@ src/wgm_pkg.sv @@
// shared types, constants and helpers for the wildcard glob matcher
`timescale 1ns / 1ps
`default_nettype none

package wgm_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int KIND_W          = 2;
    localparam int CHAR_W          = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CHAR_W-1:0] WILD_CHAR = 8'd42;
    localparam logic [CHAR_W-1:0] UPPER_A   = 8'd65;
    localparam logic [CHAR_W-1:0] UPPER_Z   = 8'd90;
    localparam logic [CHAR_W-1:0] CASE_GAP  = 8'd32;

    typedef enum logic [KIND_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] chr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c,
                                                    input logic             en);
        logic [CHAR_W-1:0] r;
        r = c;
        if (en && c >= UPPER_A && c <= UPPER_Z) begin
            r = c + CASE_GAP;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/wgm_if.sv @@
// valid/ready channel interfaces for pattern/text beats and match results
`timescale 1ns / 1ps
`default_nettype none

interface wgm_item_if;
    logic                       valid;
    logic                       ready;
    logic [wgm_pkg::KIND_W-1:0] kind;
    logic [wgm_pkg::CHAR_W-1:0] char_code;

    modport source (output valid, output kind, output char_code, input ready);
    modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface wgm_result_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

`default_nettype wire

@@ src/wgm_front.sv @@
// front end: accepts input beats, decodes the kind and folds text bytes
`timescale 1ns / 1ps
`default_nettype none

module wgm_front (
    input  wire logic          i_fold_case,
    wgm_item_if.sink           i_item,
    output wgm_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire wgm_pkg::t_q_stat i_q_stat
);

    wgm_pkg::t_op w_op;

    always_comb begin
        w_op = wgm_pkg::t_op'(i_item.kind);
        o_cmd.op = w_op;
        // text bytes are folded once here, pattern bytes are folded per cell
        if (w_op == wgm_pkg::OP_TEXT) begin
            o_cmd.chr = wgm_pkg::fold_byte(i_item.char_code, i_fold_case);
        end else begin
            o_cmd.chr = i_item.char_code;
        end
    end

    assign i_item.ready = !i_q_stat.full;
    assign o_cmd_valid  = i_item.valid;

endmodule

`default_nettype wire

@@ src/wgm_queue.sv @@
// short command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module wgm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire wgm_pkg::t_cmd    i_cmd,
    output wgm_pkg::t_q_stat      o_stat,
    output logic                  o_cmd_valid,
    output wgm_pkg::t_cmd         o_cmd,
    input  wire logic             i_pop_ready
);

    localparam int PTR_W = (wgm_pkg::QUEUE_DEPTH > 1) ? $clog2(wgm_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(wgm_pkg::QUEUE_DEPTH + 1);

    wgm_pkg::t_cmd    r_mem [wgm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic w_do_push;
    logic w_do_pop;

    assign o_stat.full  = (r_count == CNT_W'(wgm_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd_valid  = !o_stat.empty;
    assign o_cmd        = r_mem[r_rd_ptr];
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = o_cmd_valid && i_pop_ready;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(wgm_pkg::QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (w_do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ src/wgm_back.sv @@
// back end: pattern cells, active position vector and result register
`timescale 1ns / 1ps
`default_nettype none

module wgm_back #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fold_case,
    input  wire logic          i_cmd_valid,
    input  wire wgm_pkg::t_cmd i_cmd,
    output logic               o_cmd_ready,
    wgm_result_if.source       o_result
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int LEVELS = LEN_W;

    logic [wgm_pkg::CHAR_W-1:0] r_pat [MAX_PATTERN];
    logic [LEN_W-1:0]           r_len;
    logic [MAX_PATTERN:0]       r_start;
    logic [MAX_PATTERN:0]       r_act;
    logic                       r_fresh;
    logic                       r_ovf;
    logic                       r_out_valid;
    logic                       r_out_matched;
    logic                       r_out_ovf;

    logic                       w_fire;
    logic                       w_full;
    logic                       w_match;
    logic [MAX_PATTERN:0]       w_base;
    logic [MAX_PATTERN-1:0]     w_live;
    logic [MAX_PATTERN-1:0]     w_star;
    logic [MAX_PATTERN-1:0]     w_eq;
    logic [MAX_PATTERN:0]       w_adv;
    logic [MAX_PATTERN:0]       w_g [LEVELS+1];
    logic [MAX_PATTERN:0]       w_p [LEVELS+1];

    assign o_cmd_ready = !(i_cmd.op == wgm_pkg::OP_END && r_out_valid && !o_result.ready);
    assign w_fire      = i_cmd_valid && o_cmd_ready;
    assign w_full      = (r_len == LEN_W'(MAX_PATTERN));
    assign w_base      = r_fresh ? r_start : r_act;
    assign w_match     = (r_len == '0) || w_base[r_len];

    // per-cell compare, all positions in parallel
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            w_live[k] = (LEN_W'(k) < r_len);
            w_star[k] = (r_pat[k] == wgm_pkg::WILD_CHAR);
            w_eq[k]   = (wgm_pkg::fold_byte(r_pat[k], i_fold_case) == i_cmd.chr);
        end
    end

    always_comb begin
        w_adv = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (w_base[k] && w_live[k]) begin
                if (w_star[k]) begin
                    w_adv[k] = 1'b1;
                end else if (w_eq[k]) begin
                    w_adv[k+1] = 1'b1;
                end
            end
        end
    end

    // star closure as a parallel prefix: a live star at k carries k into k+1
    always_comb begin
        w_g[0] = w_adv;
        w_p[0] = {w_star & w_live, 1'b0};
        for (int lv = 0; lv < LEVELS; lv++) begin
            for (int j = 0; j <= MAX_PATTERN; j++) begin
                if (j >= (1 << lv)) begin
                    w_g[lv+1][j] = w_g[lv][j] | (w_p[lv][j] & w_g[lv][j - (1 << lv)]);
                    w_p[lv+1][j] = w_p[lv][j] & w_p[lv][j - (1 << lv)];
                end else begin
                    w_g[lv+1][j] = w_g[lv][j];
                    w_p[lv+1][j] = w_p[lv][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_start     <= {{MAX_PATTERN{1'b0}}, 1'b1};
            r_act       <= {{MAX_PATTERN{1'b0}}, 1'b1};
            r_fresh     <= 1'b1;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                case (i_cmd.op)
                    wgm_pkg::OP_CLEAR: begin
                        r_len   <= '0;
                        r_ovf   <= 1'b0;
                        r_fresh <= 1'b1;
                        r_start <= {{MAX_PATTERN{1'b0}}, 1'b1};
                    end
                    wgm_pkg::OP_APPEND: begin
                        r_fresh <= 1'b1;
                        if (!w_full) begin
                            r_len <= r_len + LEN_W'(1);
                            // start closure grows only through a leading run of stars
                            r_start[r_len + LEN_W'(1)] <= r_start[r_len] &&
                                (i_cmd.chr == wgm_pkg::WILD_CHAR);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    wgm_pkg::OP_TEXT: begin
                        r_act   <= w_g[LEVELS];
                        r_fresh <= 1'b0;
                    end
                    default: begin
                        r_fresh     <= 1'b1;
                        r_out_valid <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_cmd.op == wgm_pkg::OP_END) begin
            r_out_matched <= w_match;
            r_out_ovf     <= r_ovf;
        end
    end

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        always_ff @(posedge i_clk) begin
            if (w_fire && i_cmd.op == wgm_pkg::OP_APPEND && r_len == LEN_W'(k)) begin
                r_pat[k] <= i_cmd.chr;
            end
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.matched          = r_out_matched;
    assign o_result.pattern_overflow = r_out_ovf;

endmodule

`default_nettype wire

@@ src/wildcard_glob_matcher.sv @@
// top level of the star-only wildcard glob matcher
//
//  channel    dir  handshake      payload
//  i_text     in   valid/ready    kind, char_code
//  o_result   out  valid/ready    matched, pattern_overflow
//  cfg        in   i_cfg_we       i_cfg_wdata -> fold_case
//
// one beat per cycle sustained while the queue has room (an end-of-text beat
// waits there while an earlier result is untaken); a text byte updates every
// pattern cell and the star-closure prefix network; an accepted end-of-text
// beat goes through the queue, then the back end into the output register
// synchronous active-low reset empties the queue and loads the empty pattern
// a two-entry queue lets the front keep taking beats while a result stalls
`timescale 1ns / 1ps
`default_nettype none

module wildcard_glob_matcher #(
    parameter int MAX_PATTERN = wgm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_we,
    input  wire logic   i_cfg_wdata,
    wgm_item_if.sink    i_text,
    wgm_result_if.source o_result
);

    logic             r_fold_case;
    wgm_pkg::t_cmd    w_front_cmd;
    logic             w_front_valid;
    wgm_pkg::t_q_stat w_q_stat;
    wgm_pkg::t_cmd    w_cmd;
    logic             w_cmd_valid;
    logic             w_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_case <= 1'b0;
        end else if (i_cfg_we) begin
            r_fold_case <= i_cfg_wdata;
        end
    end

    wgm_front u_front (
        .i_fold_case (r_fold_case),
        .i_item      (i_text),
        .o_cmd       (w_front_cmd),
        .o_cmd_valid (w_front_valid),
        .i_q_stat    (w_q_stat)
    );

    wgm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_front_valid),
        .i_cmd       (w_front_cmd),
        .o_stat      (w_q_stat),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_pop_ready (w_cmd_ready)
    );

    wgm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fold_case (r_fold_case),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_result    (o_result)
    );

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_valid && w_cmd_ready && w_cmd.op == wgm_pkg::OP_END) |=> o_result.valid)
        else $error("end-of-text beat did not produce a result");

    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |->
            $past(w_cmd_valid && w_cmd_ready && w_cmd.op == wgm_pkg::OP_END))
        else $error("result raised without an end-of-text beat");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue reports full and empty together");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.empty |-> !w_cmd_valid)
        else $error("back end sees a command from an empty queue");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// self-checking testbench for the star-only wildcard glob matcher
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_PAT    = wgm_pkg::MAX_PATTERN_DEF;
    localparam int CW         = wgm_pkg::CHAR_W;
    localparam int IDLE_LIMIT = 1000;
    localparam int PHASES     = 3;
    localparam int PHASE_BUDGET = 190;
    localparam logic [CW-1:0] LOWER_A = wgm_pkg::UPPER_A + wgm_pkg::CASE_GAP;
    localparam logic [CW-1:0] LOWER_Z = wgm_pkg::UPPER_Z + wgm_pkg::CASE_GAP;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_match_result;

    // glob matcher predictor plus the queue of match flags it owes
    class match_scoreboard;
        logic [CW-1:0]     pat_bytes[MAX_PAT];
        int unsigned       pat_len;
        bit [MAX_PAT:0]    live;
        bit                overflow;
        bit                fresh;
        bit                fold;
        t_match_result     owed[$];
        int                errors;
        int                checked;
        int                hits;
        int                overflow_seen;

        function new();
            pat_len  = 0;
            overflow = 1'b0;
            fresh    = 1'b1;
            fold     = 1'b0;
            live     = '0;
            live[0]  = 1'b1;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void set_fold(bit v);
            fold = v;
        endfunction

        function logic [CW-1:0] norm(logic [CW-1:0] c);
            if (fold && c >= wgm_pkg::UPPER_A && c <= wgm_pkg::UPPER_Z) begin
                return c + wgm_pkg::CASE_GAP;
            end
            return c;
        endfunction

        // a live star also makes the next position live
        function void close_wild();
            for (int i = 0; i < pat_len; i++) begin
                if (live[i] && pat_bytes[i] == wgm_pkg::WILD_CHAR) begin
                    live[i+1] = 1'b1;
                end
            end
        endfunction

        function void restart();
            live    = '0;
            live[0] = 1'b1;
            close_wild();
            fresh = 1'b0;
        endfunction

        function void note_item(wgm_pkg::t_op op, logic [CW-1:0] c);
            bit [MAX_PAT:0] nxt;
            t_match_result  e;
            case (op)
                wgm_pkg::OP_CLEAR: begin
                    pat_len  = 0;
                    overflow = 1'b0;
                    fresh    = 1'b1;
                end
                wgm_pkg::OP_APPEND: begin
                    if (pat_len < MAX_PAT) begin
                        pat_bytes[pat_len] = c;
                        pat_len++;
                    end else begin
                        overflow = 1'b1;
                    end
                    fresh = 1'b1;
                end
                wgm_pkg::OP_TEXT: begin
                    if (fresh) begin
                        restart();
                    end
                    nxt = '0;
                    for (int i = 0; i < pat_len; i++) begin
                        if (live[i]) begin
                            if (pat_bytes[i] == wgm_pkg::WILD_CHAR) begin
                                nxt[i] = 1'b1;
                            end else if (norm(pat_bytes[i]) == norm(c)) begin
                                nxt[i+1] = 1'b1;
                            end
                        end
                    end
                    live = nxt;
                    close_wild();
                end
                default: begin
                    if (fresh) begin
                        restart();
                    end
                    e.matched  = (pat_len == 0) || live[pat_len];
                    e.overflow = overflow;
                    owed.push_back(e);
                    fresh = 1'b1;
                end
            endcase
        endfunction

        function void check_result(logic m, logic o);
            t_match_result e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("error: result matched=%0b overflow=%0b with none owed", m, o);
                end
                return;
            end
            e = owed.pop_front();
            checked++;
            if (m === 1'b1) hits++;
            if (o === 1'b1) overflow_seen++;
            if (m !== e.matched || o !== e.overflow) begin
                errors++;
                if (errors <= 10) begin
                    $display("error: result %0d matched exp %0b got %0b, overflow exp %0b got %0b",
                             checked, e.matched, m, e.overflow, o);
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_wdata = 1'b0;

    wgm_item_if   tx_if();
    wgm_result_if rx_if();

    wildcard_glob_matcher u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_text      (tx_if),
        .o_result    (rx_if)
    );

    always #6 i_clk = ~i_clk;

    match_scoreboard board = new();

    logic [CW-1:0] pat_mirror[$];
    int  items_sent;
    int  folds_written;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  tx_gaps_on;
    bit  rx_stalls_on;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // biased toward a few letters so texts match often
    function automatic logic [CW-1:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return "a";
        if (r < 45) return "b";
        if (r < 60) return "A";
        if (r < 70) return "B";
        if (r < 80) return wgm_pkg::WILD_CHAR;
        return CW'($urandom_range(0, 255));
    endfunction

    function automatic logic [CW-1:0] flip_case(logic [CW-1:0] c);
        if (c >= wgm_pkg::UPPER_A && c <= wgm_pkg::UPPER_Z) return c + wgm_pkg::CASE_GAP;
        if (c >= LOWER_A && c <= LOWER_Z) return c - wgm_pkg::CASE_GAP;
        return c;
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rx_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            rx_if.ready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
                stall_left <= pick_gap();
            end
        end
    end

    // beat monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((tx_if.valid && tx_if.ready) || (rx_if.valid && rx_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("wildcard_glob_matcher: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (tx_if.valid && tx_if.ready) begin
                board.note_item(wgm_pkg::t_op'(tx_if.kind), tx_if.char_code);
            end
            if (rx_if.valid && rx_if.ready) begin
                board.check_result(rx_if.matched, rx_if.pattern_overflow);
            end
        end
    end

    task automatic put(wgm_pkg::t_op op, logic [CW-1:0] c);
        int g;
        if (tx_gaps_on && $urandom_range(0, 99) < 30) begin
            g = pick_gap();
            tx_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        tx_if.valid     <= 1'b1;
        tx_if.kind      <= op;
        tx_if.char_code <= c;
        do @(posedge i_clk); while (!(tx_if.valid && tx_if.ready));
        items_sent++;
        if (op == wgm_pkg::OP_CLEAR) begin
            pat_mirror.delete();
        end else if (op == wgm_pkg::OP_APPEND && pat_mirror.size() < MAX_PAT) begin
            pat_mirror.push_back(c);
        end
    endtask

    task automatic write_fold(bit v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_fold(v);
        folds_written++;
    endtask

    // let queued beats without a result drain through the back end too
    task automatic settle();
        tx_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // one text built from the current pattern, mostly matching
    task automatic send_text();
        logic [CW-1:0] snap[$];
        int            r;
        snap = pat_mirror;
        foreach (snap[i]) begin
            if (snap[i] == wgm_pkg::WILD_CHAR) begin
                repeat ($urandom_range(0, 3)) put(wgm_pkg::OP_TEXT, pick_char());
            end else begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    put(wgm_pkg::OP_TEXT, pick_char());
                end else if (r >= 9) begin
                    put(wgm_pkg::OP_TEXT,
                        $urandom_range(0, 1) ? flip_case(snap[i]) : snap[i]);
                end
            end
            // pattern grows mid-text now and then
            if ($urandom_range(0, 99) < 2) begin
                put(wgm_pkg::OP_APPEND, pick_char());
            end
        end
        if ($urandom_range(0, 99) < 10) begin
            put(wgm_pkg::OP_TEXT, pick_char());
        end
        put(wgm_pkg::OP_END, CW'($urandom_range(0, 255)));
    endtask

    task automatic send_sequence(bit long_pat);
        int plen;
        int r;
        if ($urandom_range(0, 99) < 85) begin
            put(wgm_pkg::OP_CLEAR, CW'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        if (long_pat) plen = $urandom_range(62, 70);
        else if (r < 85) plen = $urandom_range(0, 8);
        else plen = $urandom_range(9, 30);
        repeat (plen) put(wgm_pkg::OP_APPEND, pick_char());
        if (long_pat) begin
            send_text();
        end else begin
            repeat ($urandom_range(1, 3)) send_text();
        end
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 5)) begin
            put(wgm_pkg::t_op'($urandom_range(0, 3)), CW'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int phase_start;
        tx_if.valid     <= 1'b0;
        tx_if.kind      <= wgm_pkg::OP_CLEAR;
        tx_if.char_code <= '0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_fold(1'b0);

        // directed: empty pattern, star in text, pattern change mid-text, extremes
        put(wgm_pkg::OP_END, 8'h00);
        put(wgm_pkg::OP_TEXT, 8'hFF);   put(wgm_pkg::OP_END, 8'h00);
        put(wgm_pkg::OP_APPEND, "a");
        put(wgm_pkg::OP_APPEND, wgm_pkg::WILD_CHAR);
        put(wgm_pkg::OP_APPEND, "B");
        put(wgm_pkg::OP_TEXT, "a");
        put(wgm_pkg::OP_TEXT, wgm_pkg::WILD_CHAR);
        put(wgm_pkg::OP_TEXT, "x");
        put(wgm_pkg::OP_TEXT, "B");     put(wgm_pkg::OP_END, 8'hFF);
        put(wgm_pkg::OP_TEXT, "a");     put(wgm_pkg::OP_TEXT, "b");
        put(wgm_pkg::OP_END, 8'h00);
        put(wgm_pkg::OP_END, 8'h00);
        put(wgm_pkg::OP_TEXT, "a");
        put(wgm_pkg::OP_APPEND, wgm_pkg::WILD_CHAR);
        put(wgm_pkg::OP_TEXT, "a");
        put(wgm_pkg::OP_TEXT, "B");     put(wgm_pkg::OP_END, 8'h00);
        put(wgm_pkg::OP_CLEAR, 8'hFF);
        put(wgm_pkg::OP_APPEND, wgm_pkg::WILD_CHAR);
        put(wgm_pkg::OP_APPEND, 8'hFF);
        put(wgm_pkg::OP_TEXT, 8'h00);   put(wgm_pkg::OP_TEXT, 8'hFF);
        put(wgm_pkg::OP_END, 8'h00);
        put(wgm_pkg::OP_APPEND, 8'h00); put(wgm_pkg::OP_END, 8'h00);
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_fold(ph % 3 != 1);
            tx_gaps_on   = (ph % 3 != 2);
            rx_stalls_on = (ph % 3 != 2);
            phase_start  = items_sent;
            send_sequence(1'b1);
            while (items_sent - phase_start < PHASE_BUDGET) begin
                if ($urandom_range(0, 99) < 85) send_sequence(1'b0);
                else send_noise();
            end
            settle();
        end

        $display("ran %0d input beats over %0d fold_case writes", items_sent, folds_written);
        $display("checked %0d results: %0d matched, %0d flagged overflow",
                 board.checked, board.hits, board.overflow_seen);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("wildcard_glob_matcher: match");
        end else begin
            $display("errors %0d, results still owed %0d", board.errors, board.pending());
            $display("wildcard_glob_matcher: mismatch");
        end
        $finish;
    end

endmodule
